// ===== rtl/pointer_acceleration_scaler_core_macros.svh =====
// Assertion macros for the pointer acceleration scaler.
// Used by the control module; relies on a clk and rst in scope.
`ifndef POINTER_ACCELERATION_SCALER_CORE_MACROS_SVH
`define POINTER_ACCELERATION_SCALER_CORE_MACROS_SVH

// next-cycle implication
`define PAS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pas assertion failed: next-cycle check");

// same-cycle implication
`define PAS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pas assertion failed: same-cycle check");

`endif

// ===== rtl/pas_pkg.sv =====
// Shared types and constants for the pointer acceleration scaler.
// No dependencies.
package pas_pkg;

  localparam int MAX_SEGMENTS = 32;
  localparam int SEG_AW       = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = 6;
  localparam int MAG_W        = 29;
  localparam int REM_W        = 30;
  localparam int DIV_STEPS    = 32;

  // register indexes
  localparam logic [1:0] REG_SCALING = 2'd0;
  localparam logic [1:0] REG_COUNT   = 2'd1;
  localparam logic [1:0] REG_BMODE   = 2'd2;
  localparam logic [1:0] REG_MULTI   = 2'd3;

  // button modes
  localparam logic [1:0] BM_TIE    = 2'd0;
  localparam logic [1:0] BM_SWAP   = 2'd1;
  localparam logic [1:0] BM_NORMAL = 2'd2;

  typedef struct packed {
    logic             scaling_enabled;
    logic [CNT_W-1:0] segment_count;
    logic [1:0]       button_mode;
    logic             multi_button;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_READ,
    OP_NEXT,
    OP_MSLOPE,
    OP_DIVSTART,
    OP_DIVSTEP,
    OP_SCALE,
    OP_MX,
    OP_MY,
    OP_FINY,
    OP_OUT
  } op_t;

  typedef struct packed {
    logic is_seg;
    logic pass;
    logic more;
    logic div_last;
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_READ,
    ST_CMP,
    ST_MSLOPE,
    ST_DIVSTART,
    ST_DIV,
    ST_SCALE,
    ST_MX,
    ST_MY,
    ST_FINY,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/pas_datapath.sv =====
// Datapath: segment table memory, speed estimate, shared multiplier,
// radix-2 divider, fraction state and button mapping. Uses pas_pkg.
module pas_datapath
  import pas_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  op_t                 op,
  input  cfg_t                cfg,
  input  logic                cmd,
  input  logic signed [11:0]  delta_x,
  input  logic signed [11:0]  delta_y,
  input  logic [7:0]          raw_buttons,
  input  logic [4:0]          seg_index,
  input  logic signed [31:0]  seg_limit,
  input  logic signed [31:0]  seg_slope,
  input  logic signed [31:0]  seg_intercept,
  output dp_status_t          status,
  output logic signed [15:0]  out_dx,
  output logic signed [15:0]  out_dy,
  output logic [7:0]          out_buttons
);

  logic signed [31:0] lim_mem [MAX_SEGMENTS];
  logic signed [31:0] slp_mem [MAX_SEGMENTS];
  logic signed [31:0] icp_mem [MAX_SEGMENTS];
  logic signed [31:0] lim_q, slp_q, icp_q;

  logic [SEG_AW-1:0]  k;
  logic [MAG_W-1:0]   mag;
  logic signed [11:0] dx, dy;
  logic [7:0]         btn_raw;
  logic               is_seg, pass;
  logic signed [63:0] prod;
  logic               t_neg;
  logic [REM_W-1:0]   rem;
  logic [31:0]        qs;
  logic [4:0]         div_cnt;
  logic signed [31:0] scale;
  logic signed [16:0] frac_x, frac_y;
  logic signed [15:0] ox, oy;
  logic [7:0]         btn_base, btn_map;

  // speed estimate from the incoming deltas
  logic [11:0]        ax_in, ay_in, mx_in, mn_in;
  logic [MAG_W-1:0]   mag_in;
  assign ax_in  = delta_x[11] ? 12'(-delta_x) : 12'(delta_x);
  assign ay_in  = delta_y[11] ? 12'(-delta_y) : 12'(delta_y);
  assign mx_in  = (ax_in > ay_in) ? ax_in : ay_in;
  assign mn_in  = (ax_in > ay_in) ? ay_in : ax_in;
  assign mag_in = {1'b0, mx_in, 16'h0} + {2'b0, mn_in, 15'h0};

  // segment count clamp: 0 acts as 1, above table size acts as table size
  logic [CNT_W:0] n_eff;
  always_comb begin
    if (cfg.segment_count == '0) n_eff = (CNT_W+1)'(1);
    else if ({1'b0, cfg.segment_count} > (CNT_W+1)'(MAX_SEGMENTS))
      n_eff = (CNT_W+1)'(MAX_SEGMENTS);
    else n_eff = {1'b0, cfg.segment_count};
  end

  // shared multiplier
  logic signed [31:0] mul_a, mul_b;
  always_comb begin
    case (op)
      OP_MSLOPE: begin
        mul_a = $signed({3'b0, mag});
        mul_b = slp_q;
      end
      OP_MX: begin
        mul_a = 32'(signed'({dx, 16'h0}));
        mul_b = scale;
      end
      OP_MY: begin
        mul_a = 32'(signed'({dy, 16'h0}));
        mul_b = scale;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic signed [31:0] prod_fx, t_sum, sum_s;
  logic [31:0]        abs_t;
  logic signed [16:0] frac_sel;
  assign prod_fx  = prod[47:16];
  assign t_sum    = icp_q + prod_fx;
  assign abs_t    = t_sum[31] ? 32'(-t_sum) : 32'(t_sum);
  assign frac_sel = (op == OP_MY) ? frac_x : frac_y;
  assign sum_s    = prod_fx + 32'(frac_sel);

  // truncation toward zero of sum_s / 65536
  logic signed [15:0] sum_int;
  assign sum_int = sum_s[31:16] + ((sum_s[31] && (sum_s[15:0] != 16'h0)) ? 16'sd1 : 16'sd0);

  // divider trial subtract
  logic [REM_W:0] trial;
  logic [REM_W-1:0] rem_sh;
  assign rem_sh = {rem[REM_W-2:0], qs[31]};
  assign trial  = {1'b0, rem_sh} - {2'b0, mag};

  always_ff @(posedge clk) begin
    if (op == OP_LOAD && cmd) begin
      lim_mem[seg_index[SEG_AW-1:0]] <= seg_limit;
      slp_mem[seg_index[SEG_AW-1:0]] <= seg_slope;
      icp_mem[seg_index[SEG_AW-1:0]] <= seg_intercept;
    end
    if (op == OP_READ) begin
      lim_q <= lim_mem[k];
      slp_q <= slp_mem[k];
      icp_q <= icp_mem[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_x <= '0;
      frac_y <= '0;
    end else begin
      case (op)
        OP_MY: frac_x <= {sum_s[31], sum_s[15:0]};
        OP_FINY: frac_y <= {sum_s[31], sum_s[15:0]};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        k       <= '0;
        mag     <= mag_in;
        dx      <= delta_x;
        dy      <= delta_y;
        btn_raw <= raw_buttons;
        is_seg  <= cmd;
        pass    <= !cfg.scaling_enabled || (mag_in == '0);
        ox      <= 16'(delta_x);
        oy      <= 16'(delta_y);
      end
      OP_NEXT: k <= k + SEG_AW'(1);
      OP_MSLOPE, OP_MX: prod <= mul_a * mul_b;
      OP_DIVSTART: begin
        t_neg   <= t_sum[31];
        rem     <= {14'h0, abs_t[31:16]};
        qs      <= {abs_t[15:0], 16'h0};
        div_cnt <= '0;
      end
      OP_DIVSTEP: begin
        if (!trial[REM_W]) begin
          rem <= trial[REM_W-1:0];
          qs  <= {qs[30:0], 1'b1};
        end else begin
          rem <= rem_sh;
          qs  <= {qs[30:0], 1'b0};
        end
        div_cnt <= div_cnt + 5'd1;
      end
      OP_SCALE: scale <= t_neg ? 32'(-qs) : 32'(qs);
      OP_MY: begin
        prod <= mul_a * mul_b;
        ox   <= sum_int;
      end
      OP_FINY: oy <= sum_int;
      OP_OUT: begin
        out_dx      <= ox;
        out_dy      <= oy;
        out_buttons <= btn_map;
      end
      default: ;
    endcase
  end

  // button remap: left to bit2; with multi_button, right to bit0 and middle to bit1; then tie or swap mode
  always_comb begin
    btn_base = {5'h0, btn_raw[0], 2'b00};
    if (cfg.multi_button) begin
      btn_base[0]   = btn_raw[1];
      btn_base[1]   = btn_raw[2];
      btn_base[7:3] = btn_raw[7:3];
    end
    btn_map = btn_base;
    if (cfg.button_mode == BM_TIE) begin
      if (btn_base[0] || btn_base[2]) begin
        btn_map[2] = 1'b1;
        btn_map[0] = 1'b0;
      end
    end else if (cfg.button_mode == BM_SWAP && cfg.multi_button) begin
      btn_map[0] = btn_base[2];
      btn_map[2] = btn_base[0];
    end
  end

  assign status.is_seg   = is_seg;
  assign status.pass     = pass;
  assign status.more     = (({2'b0, k} + (CNT_W+1)'(1)) < n_eff)
                           && ($signed({3'b0, mag}) > lim_q);
  assign status.div_last = (div_cnt == 5'(DIV_STEPS - 1));

endmodule

// ===== rtl/pas_ctrl.sv =====
// Control state machine: sequences search, divide and multiply steps.
// Uses pas_pkg and pointer_acceleration_scaler_core_macros.svh.
`include "pointer_acceleration_scaler_core_macros.svh"
module pas_ctrl
  import pas_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output op_t        op
);

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    op             = OP_NONE;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.is_seg) state_next = ST_IDLE;
        else if (status.pass) state_next = ST_OUT;
        else state_next = ST_READ;
      end
      ST_READ: begin
        op         = OP_READ;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (status.more) begin
          op         = OP_NEXT;
          state_next = ST_READ;
        end else begin
          state_next = ST_MSLOPE;
        end
      end
      ST_MSLOPE: begin
        op         = OP_MSLOPE;
        state_next = ST_DIVSTART;
      end
      ST_DIVSTART: begin
        op         = OP_DIVSTART;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        op = OP_DIVSTEP;
        if (status.div_last) state_next = ST_SCALE;
      end
      ST_SCALE: begin
        op         = OP_SCALE;
        state_next = ST_MX;
      end
      ST_MX: begin
        op         = OP_MX;
        state_next = ST_MY;
      end
      ST_MY: begin
        op         = OP_MY;
        state_next = ST_FINY;
      end
      ST_FINY: begin
        op         = OP_FINY;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          op             = OP_OUT;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `PAS_ASSERT_NEXT(a_div_to_scale, state == ST_DIV && status.div_last, state == ST_SCALE)
  `PAS_ASSERT_NEXT(a_cmp_done, state == ST_CMP && !status.more, state == ST_MSLOPE)
  `PAS_ASSERT_NOW(a_out_free, op == OP_OUT, !out_valid || out_ready)
  `PAS_ASSERT_NEXT(a_out_load, op == OP_OUT, out_valid)

endmodule

// ===== rtl/pointer_acceleration_scaler_core.sv =====
// Scaled motion request, accept to result valid: decide, a read and compare per segment
// searched, slope multiply, divider start, 32 divider steps, scale, x and y multiplies;
// scaling off or zero speed goes from decide to output; segment writes give no result.
// One request in flight: a new request is accepted only back in idle, after the output
// register has taken the result, which can wait on out_ready.
// Synchronous active-high reset clears control, config and fractions;
// segment table is not cleared.
module pointer_acceleration_scaler_core
  import pas_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic signed [11:0] delta_x,
  input  logic signed [11:0] delta_y,
  input  logic [7:0]         raw_buttons,
  input  logic [4:0]         seg_index,
  input  logic signed [31:0] seg_limit,
  input  logic signed [31:0] seg_slope,
  input  logic signed [31:0] seg_intercept,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_dx,
  output logic signed [15:0] out_dy,
  output logic [7:0]         out_buttons,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t       cfg;
  dp_status_t status;
  op_t        op;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scaling_enabled <= 1'b0;
      cfg.segment_count   <= CNT_W'(1);
      cfg.button_mode     <= BM_NORMAL;
      cfg.multi_button    <= 1'b0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_SCALING: cfg.scaling_enabled <= pwdata[0];
        REG_COUNT:   cfg.segment_count   <= pwdata[CNT_W-1:0];
        REG_BMODE:   cfg.button_mode     <= pwdata[1:0];
        REG_MULTI:   cfg.multi_button    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SCALING: prdata = {31'h0, cfg.scaling_enabled};
      REG_COUNT:   prdata = {26'h0, cfg.segment_count};
      REG_BMODE:   prdata = {30'h0, cfg.button_mode};
      REG_MULTI:   prdata = {31'h0, cfg.multi_button};
      default:     prdata = '0;
    endcase
  end

  pas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .op        (op)
  );

  pas_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .cfg           (cfg),
    .cmd           (cmd),
    .delta_x       (delta_x),
    .delta_y       (delta_y),
    .raw_buttons   (raw_buttons),
    .seg_index     (seg_index),
    .seg_limit     (seg_limit),
    .seg_slope     (seg_slope),
    .seg_intercept (seg_intercept),
    .status        (status),
    .out_dx        (out_dx),
    .out_dy        (out_dy),
    .out_buttons   (out_buttons)
  );

endmodule
